// File: hdl/rfpwd_pkg.sv
// rfpwd_pkg: shared constants and codes for the pulse-width code decoder
// no dependencies; imported by rf_pulse_width_code_decoder

package rfpwd_pkg;

	localparam int unsigned WIDTH_BITS   = 16;
	localparam int unsigned CODE_BITS    = 24;
	localparam int unsigned INDEX_BITS   = 6;
	localparam int unsigned CFG_IDX_BITS = 2;

	// pulses per frame and the last pulse that carries a bit
	localparam logic [INDEX_BITS-1:0] FRAME_PULSES   = INDEX_BITS'(50);
	localparam logic [INDEX_BITS-1:0] LAST_BIT_PULSE = INDEX_BITS'(48);
	localparam logic [INDEX_BITS-1:0] INDEX_MAX      = '1;

	typedef logic [WIDTH_BITS-1:0] width_t;
	typedef logic [CODE_BITS-1:0]  code_t;
	typedef logic [1:0]            status_t;

	// result status codes
	localparam status_t ST_NEW    = 2'd0;
	localparam status_t ST_REPEAT = 2'd1;
	localparam status_t ST_REJECT = 2'd2;
	localparam status_t ST_ZERO   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_MID_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_LIMIT   = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_WINDOW = 2'd3;

	// register reset values
	localparam width_t MID_THRESHOLD_RST = 16'd700;
	localparam width_t LONG_LIMIT_RST    = 16'd2000;
	localparam width_t SHORT_LIMIT_RST   = 16'd150;
	localparam width_t REPEAT_WINDOW_RST = 16'd200;

	// input mode codes
	localparam logic MODE_PULSE = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

endpackage

// File: hdl/rf_pulse_width_code_decoder.sv
// rf_pulse_width_code_decoder: top level of the on-off-keyed pulse-width code decoder
// depends on rfpwd_pkg

// Takes one item per transfer on the input channel: either a received pulse width
// (mode 0) or a millisecond tick (mode 1). A frame of exactly 50 pulses yields a
// 24-bit code, one bit from each of pulses 2, 4, ..., 48, MSB first; pulses 49 and
// 50 only count. The pulse marked frame_end produces one result transfer with a
// status (new, repeat suppressed, rejected, zero code rejected) and the code, which
// is zero for both reject statuses. Ticks and other pulses produce no result. An
// item enters an input register and, once it may leave it, is fully judged by one
// compare-and-shift step, which writes the frame state and the output register.
// Sustained rate is one item per clock while results are taken. The input channel
// stalls only when a frame_end pulse waits in the input register while the output
// register holds an untaken result. Configuration writes are always accepted and
// take effect on the next clock; write only while the block is idle.

module rf_pulse_width_code_decoder
	import rfpwd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [WIDTH_BITS-1:0]   cfg_data,
	// input item channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    mode,
	input  logic [WIDTH_BITS-1:0]   pulse_width,
	input  logic                    frame_start,
	input  logic                    frame_end,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              status,
	output logic [CODE_BITS-1:0]    code
);

	// configuration registers
	width_t mid_threshold_q;
	width_t long_limit_q;
	width_t short_limit_q;
	width_t repeat_window_q;

	// input register stage
	logic   valid_s1;
	logic   mode_s1;
	width_t width_s1;
	logic   start_s1;
	logic   end_s1;

	// decoder state
	logic [INDEX_BITS-1:0] pulse_index_q;
	width_t                previous_width_q;
	code_t                 shift_code_q;
	logic                  frame_bad_q;
	code_t                 last_code_q;
	width_t                elapsed_ms_q;

	// output register
	logic    out_valid_q;
	status_t status_q;
	code_t   code_q;

	// handshake control
	logic needs_out;
	logic out_free;
	logic fire;

	// next-state logic for one item
	logic [INDEX_BITS-1:0] idx_base;
	logic [INDEX_BITS-1:0] idx_next;
	code_t                 sc_base;
	code_t                 sc_next;
	logic                  bad_base;
	logic                  bad_next;
	logic                  bit_pulse;
	logic                  is_long;
	logic                  bit_bad;
	status_t               res_status;
	code_t                 res_code;
	logic                  res_new;

	assign cfg_ready = 1'b1;

	// a frame_end pulse needs room in the output register; everything else drains freely
	assign needs_out = (mode_s1 == MODE_PULSE) && end_s1;
	assign out_free  = !out_valid_q || out_ready;
	assign fire      = valid_s1 && (!needs_out || out_free);
	assign in_ready  = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_threshold_q <= MID_THRESHOLD_RST;
			long_limit_q    <= LONG_LIMIT_RST;
			short_limit_q   <= SHORT_LIMIT_RST;
			repeat_window_q <= REPEAT_WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MID_THRESHOLD: mid_threshold_q <= cfg_data;
				CFG_LONG_LIMIT:    long_limit_q    <= cfg_data;
				CFG_SHORT_LIMIT:   short_limit_q   <= cfg_data;
				CFG_REPEAT_WINDOW: repeat_window_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			width_s1 <= pulse_width;
			start_s1 <= frame_start;
			end_s1   <= frame_end;
		end
	end

	// frame_start clears the frame before this pulse counts
	always_comb begin
		idx_base = start_s1 ? '0 : pulse_index_q;
		sc_base  = start_s1 ? '0 : shift_code_q;
		bad_base = start_s1 ? 1'b0 : frame_bad_q;

		// pulse count saturates
		idx_next = (idx_base != INDEX_MAX) ? idx_base + 1'b1 : idx_base;

		// even pulses up to the last bit pulse carry a bit
		bit_pulse = !idx_next[0] && (idx_next <= LAST_BIT_PULSE);
		is_long   = width_s1 > mid_threshold_q;
		if (is_long) begin
			bit_bad = (width_s1 > long_limit_q) || (previous_width_q > mid_threshold_q);
		end else begin
			bit_bad = (width_s1 < short_limit_q) || (previous_width_q < mid_threshold_q);
		end

		sc_next  = bit_pulse ? {sc_base[CODE_BITS-2:0], is_long} : sc_base;
		bad_next = bad_base || (bit_pulse && bit_bad);

		// frame verdict
		res_new = 1'b0;
		if (bad_next || (idx_next != FRAME_PULSES)) begin
			res_status = ST_REJECT;
			res_code   = '0;
		end else if (sc_next == '0) begin
			res_status = ST_ZERO;
			res_code   = '0;
		end else if ((sc_next == last_code_q) && (elapsed_ms_q <= repeat_window_q)) begin
			res_status = ST_REPEAT;
			res_code   = sc_next;
		end else begin
			res_status = ST_NEW;
			res_code   = sc_next;
			res_new    = 1'b1;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_index_q    <= '0;
			previous_width_q <= '0;
			shift_code_q     <= '0;
			frame_bad_q      <= 1'b0;
			last_code_q      <= '0;
			elapsed_ms_q     <= '1;
		end else if (fire) begin
			if (mode_s1 == MODE_TICK) begin
				// saturating millisecond timer
				if (elapsed_ms_q != '1) begin
					elapsed_ms_q <= elapsed_ms_q + 1'b1;
				end
			end else begin
				previous_width_q <= width_s1;
				if (end_s1) begin
					// frame judged: clear frame state for the next pulse
					pulse_index_q <= '0;
					shift_code_q  <= '0;
					frame_bad_q   <= 1'b0;
					if (res_new) begin
						last_code_q  <= sc_next;
						elapsed_ms_q <= '0;
					end
				end else begin
					pulse_index_q <= idx_next;
					shift_code_q  <= sc_next;
					frame_bad_q   <= bad_next;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && needs_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && needs_out) begin
			status_q <= res_status;
			code_q   <= res_code;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign code      = code_q;

	// reject statuses always carry a zero code
	a_reject_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == ST_REJECT) || (status == ST_ZERO)) |-> code == '0)
		else $error("reject result carries nonzero code");

	// a new code is never zero
	a_new_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NEW) |-> code != '0)
		else $error("new code result is zero");

	// a new code report restarts the repeat timer and records the code
	a_new_updates: assert property (@(posedge clk) disable iff (!arst_n)
		fire && needs_out && res_new |=>
			(elapsed_ms_q == '0) && (last_code_q == code_q) && (status_q == ST_NEW))
		else $error("new code did not update repeat state");

	// after a frame_end pulse the frame state is clear
	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		fire && needs_out |=> (pulse_index_q == '0) && (shift_code_q == '0) && !frame_bad_q)
		else $error("frame state not cleared after frame end");

endmodule

// File: bench/testbench.sv
// testbench: self-checking bench for rf_pulse_width_code_decoder, with randomized frames and stalls
// depends on rfpwd_pkg and rf_pulse_width_code_decoder; holds its own decoder predictor

module testbench;
	import rfpwd_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before the run is called hung
	localparam int SETTLE_CYCLES  = 8;     // covers draining the input and output registers plus slack

	// one decoded frame as it leaves the result channel
	typedef struct packed {
		status_t status;
		code_t   code;
	} decoded_t;

	// predictor of the decoder plus the queue of frame verdicts still owed by the block
	class decoder_scoreboard;
		width_t                mid_threshold_r;
		width_t                long_limit_r;
		width_t                short_limit_r;
		width_t                window_r;
		logic [INDEX_BITS-1:0] pulse_count;
		width_t                prev_width;
		code_t                 gathered;
		bit                    frame_broken;
		code_t                 reported_code;
		width_t                ms_since_new;
		decoded_t              owed[$];
		int                    errors;

		function new();
			mid_threshold_r = MID_THRESHOLD_RST;
			long_limit_r    = LONG_LIMIT_RST;
			short_limit_r   = SHORT_LIMIT_RST;
			window_r        = REPEAT_WINDOW_RST;
			clear_frame();
			prev_width      = '0;
			reported_code   = '0;
			ms_since_new    = '1;
			errors          = 0;
		endfunction

		function void clear_frame();
			pulse_count  = '0;
			gathered     = '0;
			frame_broken = 1'b0;
		endfunction

		function void complain(string msg);
			errors++;
			$display("%s", msg);
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void write_register(logic [CFG_IDX_BITS-1:0] idx, width_t data);
			case (idx)
				CFG_MID_THRESHOLD: mid_threshold_r = data;
				CFG_LONG_LIMIT:    long_limit_r    = data;
				CFG_SHORT_LIMIT:   short_limit_r   = data;
				CFG_REPEAT_WINDOW: window_r        = data;
				default: ;
			endcase
		endfunction

		// one accepted input transfer; a frame_end pulse owes one verdict
		function void note_item(logic m, width_t w, logic st, logic fin);
			decoded_t verdict;
			logic     b;
			if (m == MODE_TICK) begin
				if (ms_since_new != '1)
					ms_since_new = ms_since_new + 1'b1;
				return;
			end
			if (st)
				clear_frame();
			if (pulse_count != INDEX_MAX)
				pulse_count = pulse_count + 1'b1;
			// even pulses up to the last bit pulse carry the code, the odd one before is the gap
			if (!pulse_count[0] && pulse_count <= LAST_BIT_PULSE) begin
				if (w > mid_threshold_r) begin
					b = 1'b1;
					if (w > long_limit_r || prev_width > mid_threshold_r)
						frame_broken = 1'b1;
				end else begin
					b = 1'b0;
					if (w < short_limit_r || prev_width < mid_threshold_r)
						frame_broken = 1'b1;
				end
				gathered = {gathered[CODE_BITS-2:0], b};
			end
			prev_width = w;
			if (!fin)
				return;
			if (frame_broken || pulse_count != FRAME_PULSES) begin
				verdict.status = ST_REJECT;
				verdict.code   = '0;
			end else if (gathered == '0) begin
				verdict.status = ST_ZERO;
				verdict.code   = '0;
			end else if (gathered == reported_code && ms_since_new <= window_r) begin
				verdict.status = ST_REPEAT;
				verdict.code   = gathered;
			end else begin
				verdict.status = ST_NEW;
				verdict.code   = gathered;
				reported_code  = gathered;
				ms_since_new   = '0;
			end
			clear_frame();
			owed.push_back(verdict);
		endfunction

		// one accepted result transfer against the oldest owed verdict
		function void check_result(status_t got_status, code_t got_code);
			decoded_t want;
			if (owed.size() == 0) begin
				complain($sformatf("%0t: result with nothing owed, expected none, got status %0d code %h",
					$time, got_status, got_code));
				return;
			end
			want = owed.pop_front();
			if (got_status !== want.status)
				complain($sformatf("%0t: status mismatch, expected %0d, got %0d",
					$time, want.status, got_status));
			if (got_code !== want.code)
				complain($sformatf("%0t: code mismatch, expected %h, got %h",
					$time, want.code, got_code));
		endfunction
	endclass

	// block ports, all inputs known from time zero
	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    cfg_valid   = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index   = CFG_MID_THRESHOLD;
	width_t                  cfg_data    = '0;
	logic                    in_valid    = 1'b0;
	logic                    in_ready;
	logic                    mode        = MODE_PULSE;
	width_t                  pulse_width = '0;
	logic                    frame_start = 1'b0;
	logic                    frame_end   = 1'b0;
	logic                    out_valid;
	logic                    out_ready   = 1'b0;
	status_t                 status;
	code_t                   code;

	decoder_scoreboard sb;

	// handshake flags seen at the rising edge, read by the drivers at the falling edge
	bit in_taken  = 1'b0;
	bit cfg_taken = 1'b0;

	// idling knobs, percent of cycles
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// the settings the stimulus aims its widths at
	width_t aim_mid   = MID_THRESHOLD_RST;
	width_t aim_long  = LONG_LIMIT_RST;
	width_t aim_short = SHORT_LIMIT_RST;

	code_t last_sent_code = '0;
	int    items_sent     = 0;
	int    frames_closed  = 0;
	int    quiet_cycles   = 0;

	rf_pulse_width_code_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.pulse_width (pulse_width),
		.frame_start (frame_start),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.code        (code)
	);

	always #5 clk = ~clk;

	// monitor: every transfer is taken at the rising edge with pre-edge values
	always @(posedge clk) begin
		in_taken  = in_valid && in_ready;
		cfg_taken = cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_taken)
				sb.write_register(cfg_index, cfg_data);
			if (out_valid && out_ready)
				sb.check_result(status, code);
			if (in_taken)
				sb.note_item(mode, pulse_width, frame_start, frame_end);
		end
	end

	// watchdog: too long without any transfer means the block hung
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: stalls at random, rate set per phase
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// random width in [lo, hi], often right on a bound; anything when the range is empty
	function automatic width_t pick_width(int lo, int hi);
		if (lo > hi)
			return width_t'($urandom);
		case ($urandom_range(7))
			0:       return width_t'(lo);
			1:       return width_t'(hi);
			default: return width_t'($urandom_range(hi, lo));
		endcase
	endfunction

	// one input transfer, after a random sender gap; valid is only lowered inside the gap
	task automatic drive_item(logic m, width_t w, logic st, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		pulse_width <= w;
		frame_start <= st;
		frame_end   <= fin;
		do @(negedge clk); while (!in_taken);
		items_sent++;
		if (m == MODE_PULSE && fin)
			frames_closed++;
	endtask

	// sender pauses until every owed verdict is out and the pipeline has emptied
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_one(logic [CFG_IDX_BITS-1:0] idx, width_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(negedge clk); while (!cfg_taken);
	endtask

	// all four registers back to back, valid held high across them
	task automatic write_config(width_t m, width_t l, width_t s, width_t wnd);
		aim_mid   = m;
		aim_long  = l;
		aim_short = s;
		write_one(CFG_MID_THRESHOLD, m);
		write_one(CFG_LONG_LIMIT, l);
		write_one(CFG_SHORT_LIMIT, s);
		write_one(CFG_REPEAT_WINDOW, wnd);
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_config(int sel);
		int m;
		m = $urandom_range(30000, 200);
		case (sel)
			0: write_config(MID_THRESHOLD_RST, LONG_LIMIT_RST, SHORT_LIMIT_RST, REPEAT_WINDOW_RST);
			1: write_config(width_t'(m), width_t'($urandom_range(65535, m + 1)),
				width_t'($urandom_range(m, 0)), width_t'($urandom_range(300, 0)));
			2: write_config(width_t'(m), width_t'($urandom_range(65535, m + 1)),
				width_t'($urandom_range(m, 0)), width_t'($urandom_range(10, 0)));
			// low extremes: only zero-width zeros, window never closes
			3: write_config(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
			// high extremes: widths pinned near the top, window zero
			4: write_config(16'hFFFE, 16'hFFFF, 16'hFFFE, 16'd0);
			// inverted limits: every frame with a one bit is bad
			5: write_config(16'hFFFF, 16'd0, 16'hFFFF, width_t'($urandom));
			6: write_config(width_t'(m), width_t'($urandom_range(65535, m + 1)),
				width_t'($urandom_range(m, 0)), width_t'($urandom_range(60, 0)));
			default: write_config(width_t'($urandom), width_t'($urandom), width_t'($urandom),
				width_t'($urandom));
		endcase
	endtask

	// a frame of len pulses aimed at code c; bad_at names an even pulse to spoil, 0 for none
	task automatic send_frame(code_t c, bit with_start, int len, int bad_at);
		width_t w;
		logic   b;
		int     k;
		int     spoil_gap;
		spoil_gap = $urandom_range(1);
		for (int p = 1; p <= len; p++) begin
			w = width_t'($urandom);
			if (p <= 48) begin
				k = (p + 1) / 2;  // bit number of this pulse pair, 1 is the msb
				b = c[CODE_BITS - k];
				if (p % 2 == 0) begin
					// the bit pulse: long for a one, short for a zero
					if (p == bad_at && !spoil_gap)
						w = b ? pick_width(aim_long + 1, 65535) : pick_width(0, aim_short - 1);
					else
						w = b ? pick_width(aim_mid + 1, aim_long) : pick_width(aim_short, aim_mid);
				end else begin
					// the gap before it must sit on the other side of the mid threshold
					if (p + 1 == bad_at && spoil_gap)
						w = b ? pick_width(aim_mid + 1, 65535) : pick_width(0, aim_mid - 1);
					else
						w = b ? pick_width(0, aim_mid) : pick_width(aim_mid, 65535);
				end
			end
			drive_item(MODE_PULSE, w, with_start && p == 1, p == len);
		end
	endtask

	// one random stretch: some ticks, then a frame of some kind
	task automatic send_unit();
		int    r;
		int    n;
		int    len;
		code_t c;
		r = $urandom_range(99);
		// mostly short tick runs so repeats land inside the window, now and then a long one
		n = ($urandom_range(19) == 0) ? $urandom_range(400, 50) : $urandom_range(6, 0);
		repeat (n) drive_item(MODE_TICK, width_t'($urandom), 1'($urandom), 1'($urandom));
		case ($urandom_range(9))
			0:       c = '1;
			1:       c = code_t'(1);
			2:       c = {1'b1, {(CODE_BITS-1){1'b0}}};
			default: c = code_t'($urandom);
		endcase
		if (r < 40) begin
			send_frame(c, 1'b1, 50, 0);
			last_sent_code = c;
		end else if (r < 55) begin
			// same code again, repeat or new depending on the ticks
			send_frame(last_sent_code, 1'b1, 50, 0);
		end else if (r < 60) begin
			send_frame('0, 1'b1, 50, 0);
		end else if (r < 68) begin
			send_frame(c, 1'b1, 50, 2 * $urandom_range(24, 1));
		end else if (r < 76) begin
			// wrong pulse count, short, long or past the count saturation
			case ($urandom_range(2))
				0:       len = $urandom_range(49, 2);
				1:       len = $urandom_range(60, 51);
				default: len = $urandom_range(75, 63);
			endcase
			send_frame(c, 1'b1, len, 0);
		end else if (r < 82) begin
			// abandoned partial frame, then a fresh start cuts it off
			n = $urandom_range(30, 1);
			for (int i = 0; i < n; i++)
				drive_item(MODE_PULSE, width_t'($urandom), i == 0, 1'b0);
			send_frame(c, 1'b1, 50, 0);
			last_sent_code = c;
		end else if (r < 87) begin
			// frame relying on the clear after the previous frame_end
			send_frame(c, 1'b0, 50, 0);
			last_sent_code = c;
		end else if (r < 92) begin
			// start and end on the same pulse
			drive_item(MODE_PULSE, width_t'($urandom), 1'b1, 1'b1);
		end else begin
			repeat ($urandom_range(5, 1))
				drive_item(1'($urandom), width_t'($urandom), 1'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		int items_mark;
		int frames_mark;
		sb = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: ticks at saturation with every other field set, then tiny frames
		drive_item(MODE_TICK, '1, 1'b1, 1'b1);
		drive_item(MODE_TICK, '0, 1'b0, 1'b0);
		drive_item(MODE_PULSE, '0, 1'b1, 1'b1);             // start and end together
		drive_item(MODE_PULSE, '1, 1'b1, 1'b0);             // three-pulse frame
		drive_item(MODE_PULSE, '0, 1'b0, 1'b0);
		drive_item(MODE_PULSE, MID_THRESHOLD_RST, 1'b0, 1'b1);
		drive_item(MODE_PULSE, 16'd1, 1'b0, 1'b1);          // lone pulse with no start

		// four idling phases, two register settings in each, a full drain between them
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			for (int half = 0; half < 2; half++) begin
				settle();
				pick_config(2 * ph + half);
				items_mark  = items_sent;
				frames_mark = frames_closed;
				while (items_sent - items_mark < 130 || frames_closed - frames_mark < 2)
					send_unit();
			end
		end

		settle();
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: rf_pulse_width_code_decoder.f
hdl/rfpwd_pkg.sv
hdl/rf_pulse_width_code_decoder.sv
bench/testbench.sv
